// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the thermostat RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define SHT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define SHT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sht_pkg.sv =====
// Shared types and constants for the staged heater thermostat.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sht_pkg;

    // Sample and field widths
    localparam int SAMPLE_W     = 9;
    localparam int CTL_PER_W    = 8;
    localparam int REP_PER_W    = 8;
    localparam int ROT_PER_W    = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int HEATER_W     = 3;
    localparam int RELAY_W      = 4;
    localparam int RELAY_IDX_W  = 2;
    localparam int STATUS_W     = 7;

    // Default history depth
    localparam int AVG_DEPTH_DEF = 10;

    // Register reset values
    localparam logic signed [SAMPLE_W-1:0] OFF_THR_RST  = 9'sd54;
    localparam logic signed [SAMPLE_W-1:0] ST1_THR_RST  = 9'sd46;
    localparam logic signed [SAMPLE_W-1:0] ST2_THR_RST  = 9'sd38;
    localparam logic signed [SAMPLE_W-1:0] ST3_THR_RST  = 9'sd30;
    localparam logic [CTL_PER_W-1:0]       CTL_PER_RST  = 8'd4;
    localparam logic [REP_PER_W-1:0]       REP_PER_RST  = 8'd8;
    localparam logic [ROT_PER_W-1:0]       ROT_PER_RST  = 10'd80;
    localparam logic [RELAY_IDX_W-1:0]     FLOAT_ACT_RST = 2'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF_THR    = 3'd0,
        CFG_ST1_THR    = 3'd1,
        CFG_ST2_THR    = 3'd2,
        CFG_ST3_THR    = 3'd3,
        CFG_CTL_PERIOD = 3'd4,
        CFG_REP_PERIOD = 3'd5,
        CFG_ROT_PERIOD = 3'd6
    } cfg_idx_t;

    // Per-round schedule decided when the round is accepted
    typedef struct packed {
        logic                   do_control;
        logic                   do_report;
        logic [RELAY_W-1:0]     relay_pre;   // one-hot float relay before rotation
        logic [RELAY_IDX_W-1:0] relay_idx;   // float relay index after rotation
    } event_t;

endpackage

// ===== rtl/sht_avg_lane.sv =====
// One averaging lane: sample history, running sum and a constant divider.
// Depends on sht_pkg.
`timescale 1ns / 1ps

module sht_avg_lane #(
    parameter int AVG_DEPTH = sht_pkg::AVG_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  logic                                prime,
    input  logic signed [sht_pkg::SAMPLE_W-1:0] sample,
    input  logic                                load,
    output logic signed [sht_pkg::SAMPLE_W-1:0] mean
);
    import sht_pkg::*;

    localparam int DepthW = $clog2(AVG_DEPTH);
    localparam int SumW   = SAMPLE_W + DepthW;
    localparam int ShiftW = SumW + DepthW;
    localparam int RecipW = SumW + 1;
    localparam int ProdW  = SumW + RecipW;
    // ceil(2^ShiftW / depth): exact floor quotient for any SumW-bit magnitude
    localparam longint RecipVal = ((64'd1 << ShiftW) + AVG_DEPTH - 1) / AVG_DEPTH;

    logic signed [SAMPLE_W-1:0] hist_reg [AVG_DEPTH];
    logic signed [SumW-1:0]     sum_reg, sum_next;
    logic [SumW-1:0]            mag;
    logic [ProdW-1:0]           prod_reg;
    logic                       neg_reg;
    logic [SAMPLE_W-1:0]        quot;

    // Running sum: fill on the first round, else drop oldest and add newest
    always_comb begin
        if (prime) begin
            sum_next = SumW'(sample * AVG_DEPTH);
        end else begin
            sum_next = sum_reg - SumW'(hist_reg[0]) + SumW'(sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (push) begin
            sum_reg <= sum_next;
        end
    end

    // History shift line, oldest entry at index zero
    always_ff @(posedge aclk) begin
        if (push) begin
            for (int i = 0; i < AVG_DEPTH - 1; i++) begin
                hist_reg[i] <= prime ? sample : hist_reg[i + 1];
            end
            hist_reg[AVG_DEPTH - 1] <= sample;
        end
    end

    // Divide stage: magnitude times reciprocal, sign kept aside
    assign mag = sum_reg[SumW-1] ? SumW'(-sum_reg) : SumW'(sum_reg);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= ProdW'(mag) * ProdW'(RecipVal);
            neg_reg  <= sum_reg[SumW-1];
        end
    end

    // Truncation toward zero: divide magnitude, then restore sign
    assign quot = prod_reg[ShiftW +: SAMPLE_W];
    assign mean = neg_reg ? $signed(-quot) : $signed(quot);

endmodule

// ===== rtl/sht_sched.sv =====
// Round scheduler: control, report and rotate counters plus float relay pointer.
// Depends on sht_pkg.
`timescale 1ns / 1ps

module sht_sched (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic [sht_pkg::CTL_PER_W-1:0]    control_period,
    input  logic [sht_pkg::REP_PER_W-1:0]    report_period,
    input  logic [sht_pkg::ROT_PER_W-1:0]    rotate_period,
    output sht_pkg::event_t                  ev
);
    import sht_pkg::*;

    logic [CTL_PER_W-1:0]   ctl_cnt_reg, ctl_cnt_next, ctl_per;
    logic [REP_PER_W-1:0]   rep_cnt_reg, rep_cnt_next, rep_per;
    logic [ROT_PER_W-1:0]   rot_cnt_reg, rot_cnt_next, rot_per;
    logic [CTL_PER_W:0]     ctl_inc;
    logic [REP_PER_W:0]     rep_inc;
    logic [ROT_PER_W:0]     rot_inc;
    logic [RELAY_IDX_W-1:0] float_act_reg, float_nxt_reg;
    logic                   do_rotate;

    // Zero period behaves as one
    assign ctl_per = (control_period == '0) ? CTL_PER_W'(1) : control_period;
    assign rep_per = (report_period == '0) ? REP_PER_W'(1) : report_period;
    assign rot_per = (rotate_period == '0) ? ROT_PER_W'(1) : rotate_period;

    // Counters wrap once they reach or pass the period
    always_comb begin
        ctl_inc      = {1'b0, ctl_cnt_reg} + 1'b1;
        rep_inc      = {1'b0, rep_cnt_reg} + 1'b1;
        rot_inc      = {1'b0, rot_cnt_reg} + 1'b1;
        ctl_cnt_next = (ctl_inc >= {1'b0, ctl_per}) ? '0 : ctl_inc[CTL_PER_W-1:0];
        rep_cnt_next = (rep_inc >= {1'b0, rep_per}) ? '0 : rep_inc[REP_PER_W-1:0];
        rot_cnt_next = (rot_inc >= {1'b0, rot_per}) ? '0 : rot_inc[ROT_PER_W-1:0];
    end

    assign do_rotate = (rot_cnt_reg == '0);

    always_comb begin
        ev.do_control = (ctl_cnt_reg == '0);
        ev.do_report  = (rep_cnt_reg == '0);
        ev.relay_pre  = RELAY_W'(1) << float_act_reg;
        ev.relay_idx  = do_rotate ? float_nxt_reg : float_act_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_cnt_reg   <= '0;
            rep_cnt_reg   <= '0;
            rot_cnt_reg   <= '0;
            float_act_reg <= FLOAT_ACT_RST;
            float_nxt_reg <= '0;
        end else if (accept) begin
            ctl_cnt_reg <= ctl_cnt_next;
            rep_cnt_reg <= rep_cnt_next;
            rot_cnt_reg <= rot_cnt_next;
            if (do_rotate) begin
                float_act_reg <= float_nxt_reg;
                float_nxt_reg <= float_nxt_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sht_merge.sv =====
// Merge stage: heater staging from the box mean, status byte, result register.
// Depends on sht_pkg.
`timescale 1ns / 1ps

module sht_merge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  logic signed [sht_pkg::SAMPLE_W-1:0]   amb_mean,
    input  logic signed [sht_pkg::SAMPLE_W-1:0]   box_mean,
    input  sht_pkg::event_t                       ev,
    input  logic signed [sht_pkg::SAMPLE_W-1:0]   off_thr,
    input  logic signed [sht_pkg::SAMPLE_W-1:0]   st1_thr,
    input  logic signed [sht_pkg::SAMPLE_W-1:0]   st2_thr,
    input  logic signed [sht_pkg::SAMPLE_W-1:0]   st3_thr,
    output logic signed [sht_pkg::SAMPLE_W-1:0]   ambient_average,
    output logic signed [sht_pkg::SAMPLE_W-1:0]   box_average,
    output logic                                  heater_one_on,
    output logic                                  heater_two_on,
    output logic                                  heater_three_on,
    output logic [sht_pkg::RELAY_IDX_W-1:0]       float_relay_index,
    output logic                                  report_valid,
    output logic [sht_pkg::STATUS_W-1:0]          status_byte
);
    import sht_pkg::*;

    logic [HEATER_W-1:0]    heater_reg, heater_next;
    logic signed [SAMPLE_W-1:0] amb_reg, box_reg;
    logic [RELAY_IDX_W-1:0] relay_reg;
    logic                   report_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;

    // On control rounds stage one holds between thresholds; stages two and three follow theirs
    always_comb begin
        heater_next = heater_reg;
        if (ev.do_control) begin
            if (box_mean > off_thr) begin
                heater_next[0] = 1'b0;
            end else if (box_mean < st1_thr) begin
                heater_next[0] = 1'b1;
            end
            heater_next[1] = (box_mean < st2_thr);
            heater_next[2] = (box_mean < st3_thr);
        end
    end

    // Status taken before this round's updates
    assign status_next = ev.do_report ? {heater_reg, ev.relay_pre} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heater_reg <= '0;
        end else if (load) begin
            heater_reg <= heater_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            amb_reg    <= amb_mean;
            box_reg    <= box_mean;
            relay_reg  <= ev.relay_idx;
            report_reg <= ev.do_report;
            status_reg <= status_next;
        end
    end

    assign ambient_average   = amb_reg;
    assign box_average       = box_reg;
    assign heater_one_on     = heater_reg[0];
    assign heater_two_on     = heater_reg[1];
    assign heater_three_on   = heater_reg[2];
    assign float_relay_index = relay_reg;
    assign report_valid      = report_reg;
    assign status_byte       = status_reg;

endmodule

// ===== rtl/staged_heater_thermostat_top.sv =====
// Staged heater thermostat: two averaging lanes, scheduler and merge stage.
// Throughput: one round per cycle unless m_ready stalls the output; a round passes
// in order through three stages (sum, reciprocal multiply, result register), which
// pass items on independently and fill bubbles under stall.
// Reset (aresetn, synchronous, active low) restores register defaults,
// clears sums, counters, heaters and valids; the history fills on the first round.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module staged_heater_thermostat_top #(
    parameter int AVG_DEPTH = sht_pkg::AVG_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [sht_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sht_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // measurement rounds in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sht_pkg::SAMPLE_W-1:0] s_ambient_sample,
    input  logic signed [sht_pkg::SAMPLE_W-1:0] s_box_sample,
    // results out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sht_pkg::SAMPLE_W-1:0] m_ambient_average,
    output logic signed [sht_pkg::SAMPLE_W-1:0] m_box_average,
    output logic                                m_heater_one_on,
    output logic                                m_heater_two_on,
    output logic                                m_heater_three_on,
    output logic [sht_pkg::RELAY_IDX_W-1:0]     m_float_relay_index,
    output logic                                m_report_valid,
    output logic [sht_pkg::STATUS_W-1:0]        m_status_byte
);
    import sht_pkg::*;

    logic signed [SAMPLE_W-1:0] off_thr_reg, st1_thr_reg, st2_thr_reg, st3_thr_reg;
    logic [CTL_PER_W-1:0]       ctl_per_reg;
    logic [REP_PER_W-1:0]       rep_per_reg;
    logic [ROT_PER_W-1:0]       rot_per_reg;

    logic   p1_v_reg, p2_v_reg, out_v_reg;
    logic   out_free, p2_free, p1_adv, p2_adv, accept;
    logic   primed_reg;
    event_t ev_new, p1_ev_reg, p2_ev_reg;
    logic signed [SAMPLE_W-1:0] amb_mean, box_mean;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_thr_reg <= OFF_THR_RST;
            st1_thr_reg <= ST1_THR_RST;
            st2_thr_reg <= ST2_THR_RST;
            st3_thr_reg <= ST3_THR_RST;
            ctl_per_reg <= CTL_PER_RST;
            rep_per_reg <= REP_PER_RST;
            rot_per_reg <= ROT_PER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OFF_THR:    off_thr_reg <= $signed(cfg_wr_data[SAMPLE_W-1:0]);
                CFG_ST1_THR:    st1_thr_reg <= $signed(cfg_wr_data[SAMPLE_W-1:0]);
                CFG_ST2_THR:    st2_thr_reg <= $signed(cfg_wr_data[SAMPLE_W-1:0]);
                CFG_ST3_THR:    st3_thr_reg <= $signed(cfg_wr_data[SAMPLE_W-1:0]);
                CFG_CTL_PERIOD: ctl_per_reg <= cfg_wr_data[CTL_PER_W-1:0];
                CFG_REP_PERIOD: rep_per_reg <= cfg_wr_data[REP_PER_W-1:0];
                CFG_ROT_PERIOD: rot_per_reg <= cfg_wr_data[ROT_PER_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshakes: each stage moves on when the one after it is free
    assign out_free = !out_v_reg || m_ready;
    assign p2_free  = !p2_v_reg || out_free;
    assign p2_adv   = p2_v_reg && out_free;
    assign p1_adv   = p1_v_reg && p2_free;
    assign s_ready  = !p1_v_reg || p2_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg   <= 1'b0;
            p2_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            primed_reg <= 1'b0;
        end else begin
            p1_v_reg  <= accept || (p1_v_reg && !p2_free);
            p2_v_reg  <= p1_adv || (p2_v_reg && !out_free);
            out_v_reg <= p2_adv || (out_v_reg && !m_ready);
            if (accept) begin
                primed_reg <= 1'b1;
            end
        end
    end

    // Schedule travels alongside the lanes
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ev_reg <= ev_new;
        end
        if (p1_adv) begin
            p2_ev_reg <= p1_ev_reg;
        end
    end

    sht_sched u_sched (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .control_period (ctl_per_reg),
        .report_period  (rep_per_reg),
        .rotate_period  (rot_per_reg),
        .ev             (ev_new)
    );

    sht_avg_lane #(.AVG_DEPTH(AVG_DEPTH)) u_lane_amb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .prime   (!primed_reg),
        .sample  (s_ambient_sample),
        .load    (p1_adv),
        .mean    (amb_mean)
    );

    sht_avg_lane #(.AVG_DEPTH(AVG_DEPTH)) u_lane_box (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .prime   (!primed_reg),
        .sample  (s_box_sample),
        .load    (p1_adv),
        .mean    (box_mean)
    );

    sht_merge u_merge (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (p2_adv),
        .amb_mean          (amb_mean),
        .box_mean          (box_mean),
        .ev                (p2_ev_reg),
        .off_thr           (off_thr_reg),
        .st1_thr           (st1_thr_reg),
        .st2_thr           (st2_thr_reg),
        .st3_thr           (st3_thr_reg),
        .ambient_average   (m_ambient_average),
        .box_average       (m_box_average),
        .heater_one_on     (m_heater_one_on),
        .heater_two_on     (m_heater_two_on),
        .heater_three_on   (m_heater_three_on),
        .float_relay_index (m_float_relay_index),
        .report_valid      (m_report_valid),
        .status_byte       (m_status_byte)
    );

    // Checks
    `SHT_ASSERT_IMP(a_relay_onehot, aclk, aresetn, m_valid && m_report_valid, $onehot(m_status_byte[RELAY_W-1:0]), "report without exactly one float relay")
    `SHT_ASSERT_IMP(a_quiet_status, aclk, aresetn, m_valid && !m_report_valid, m_status_byte == '0, "status byte set on a non-report round")
    `SHT_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_ready, p1_v_reg && p2_v_reg && out_v_reg, "input stalled with a free stage")
    `SHT_ASSERT_NXT(a_accept_held, aclk, aresetn, accept, p1_v_reg, "accepted round lost from first stage")

endmodule
